// ----- hdl/ground_distance_from_group_path_defines.svh -----
// ----------------------------------------------------------------------------
// Ground distance from group path - assertion macros
// Concurrent assertion helpers used by the top-level RTL.
// ----------------------------------------------------------------------------
`ifndef GROUND_DISTANCE_FROM_GROUP_PATH_DEFINES_SVH
`define GROUND_DISTANCE_FROM_GROUP_PATH_DEFINES_SVH

// same-cycle implication
`define GDGP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GDGP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gdgp_pkg.sv -----
// ----------------------------------------------------------------------------
// gdgp_pkg
// Widths, reset values, codes and shared types of the ground distance block.
// ----------------------------------------------------------------------------
package gdgp_pkg;

  localparam int unsigned PATH_W     = 16;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned RCOEF_W    = 22;
  localparam int unsigned OFFS_W     = 16;
  localparam int unsigned DCOEF_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned RAW_W      = 24;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [RCOEF_W-1:0] RCOEF_RST = 22'd2655891;
  localparam logic [OFFS_W-1:0]  OFFS_RST  = 16'd208;
  localparam logic [DCOEF_W-1:0] DCOEF_RST = 16'd37954;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_PATH  = 2'd1,
    STAT_DIV_ZERO = 2'd2
  } gdgp_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_COEFF    = 2'd0,
    CFG_FREQ_OFFSET    = 2'd1,
    CFG_DISTANCE_COEFF = 2'd2
  } gdgp_cfg_idx_t;

  typedef struct packed {
    logic [RCOEF_W-1:0] range_coeff;
    logic [OFFS_W-1:0]  freq_offset;
    logic [DCOEF_W-1:0] distance_coeff;
  } gdgp_cfg_t;

  typedef struct packed {
    logic [PATH_W-1:0] group_path;
    logic [FREQ_W-1:0] sounding_freq;
    logic [FREQ_W-1:0] critical_freq;
    logic [RAW_W-1:0]  raw;
    gdgp_status_t      status;
  } gdgp_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gdgp_qstat_t;

endpackage

// ----- hdl/gdgp_if.sv -----
// ----------------------------------------------------------------------------
// gdgp_if
// Valid/ready channels for echoes in and ground distance results out.
// ----------------------------------------------------------------------------
interface gdgp_in_if;
  import gdgp_pkg::*;
  logic              valid;
  logic              ready;
  logic [PATH_W-1:0] group_path;
  logic [FREQ_W-1:0] sounding_freq;
  modport source (output valid, output group_path, output sounding_freq, input ready);
  modport sink (input valid, input group_path, input sounding_freq, output ready);
endinterface

interface gdgp_out_if;
  import gdgp_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] ground_distance;
  logic [FREQ_W-1:0] critical_freq;
  logic [STAT_W-1:0] status;
  modport source (output valid, output ground_distance, output critical_freq,
                  output status, input ready);
  modport sink (input valid, input ground_distance, input critical_freq,
                input status, output ready);
endinterface

// ----- hdl/gdgp_div.sv -----
// ----------------------------------------------------------------------------
// gdgp_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module gdgp_div #(
  parameter int unsigned NUM_W  = 30,
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned SIDE_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld_r  [NUM_W];
  logic [NUM_W-1:0]  nq_r   [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic              vld_i;
    logic [NUM_W-1:0]  nq_i;
    logic [DEN_W-1:0]  rem_i;
    logic [DEN_W-1:0]  den_i;
    logic [SIDE_W-1:0] side_i;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              take;

    if (s == 0) begin : g_first
      assign vld_i  = in_valid;
      assign nq_i   = num;
      assign rem_i  = '0;
      assign den_i  = den;
      assign side_i = side_in;
    end else begin : g_next
      assign vld_i  = vld_r[s-1];
      assign nq_i   = nq_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign den_i  = den_r[s-1];
      assign side_i = side_r[s-1];
    end

    assign trial = {rem_i, nq_i[NUM_W-1]};
    assign diff  = trial - {1'b0, den_i};
    assign take  = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_r[s]   <= {nq_i[NUM_W-2:0], take};
        den_r[s]  <= den_i;
        side_r[s] <= side_i;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign quo       = nq_r[NUM_W-1];
  assign side_out  = side_r[NUM_W-1];

endmodule

// ----- hdl/gdgp_fifo.sv -----
// ----------------------------------------------------------------------------
// gdgp_fifo
// Short queue of classified echoes between the front and back pipelines.
// ----------------------------------------------------------------------------
module gdgp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  gdgp_pkg::gdgp_item_t  wr_item,
  input  logic                  pop,
  output gdgp_pkg::gdgp_item_t  rd_item,
  output gdgp_pkg::gdgp_qstat_t qstat
);
  import gdgp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  gdgp_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item     = mem_r[rd_ptr_r];
  assign qstat.full  = (cnt_r == CNT_W'(DEPTH));
  assign qstat.empty = (cnt_r == '0);

endmodule

// ----- hdl/gdgp_front.sv -----
// ----------------------------------------------------------------------------
// gdgp_front
// Accepts echoes, estimates the critical frequency and classifies errors.
// ----------------------------------------------------------------------------
module gdgp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  gdgp_in_if.sink               in_ch,
  input  gdgp_pkg::gdgp_cfg_t   cfg,
  input  gdgp_pkg::gdgp_qstat_t qstat,
  output logic                  push,
  output gdgp_pkg::gdgp_item_t  item
);
  import gdgp_pkg::*;

  localparam int unsigned PROD_W = RCOEF_W + FREQ_W;
  localparam int unsigned PRE_SH = 8;
  localparam int unsigned QUO_W  = PROD_W - PRE_SH;
  localparam int unsigned SIDE_W = PATH_W + FREQ_W;

  logic              en;
  logic [PROD_W-1:0] prod;
  logic              vld_r;
  logic [PROD_W-1:0] prod_r;
  logic [PATH_W-1:0] path_r;
  logic [FREQ_W-1:0] freq_r;
  logic              div_vld;
  logic [QUO_W-1:0]  quo;
  logic [SIDE_W-1:0] side;
  logic [PATH_W-1:0] path;
  logic [FREQ_W-1:0] freq;
  logic [QUO_W:0]    raw;

  assign en          = !(div_vld && qstat.full);
  assign in_ch.ready = en;
  assign prod        = {{FREQ_W{1'b0}}, cfg.range_coeff} * {{RCOEF_W{1'b0}}, in_ch.sounding_freq};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod;
      path_r <= in_ch.group_path;
      freq_r <= in_ch.sounding_freq;
    end
  end

  gdgp_div #(
    .NUM_W  (QUO_W),
    .DEN_W  (PATH_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_r),
    .num       (prod_r[PROD_W-1:PRE_SH]),
    .den       (path_r),
    .side_in   ({path_r, freq_r}),
    .out_valid (div_vld),
    .quo       (quo),
    .side_out  (side)
  );

  assign path = side[SIDE_W-1:FREQ_W];
  assign freq = side[FREQ_W-1:0];
  assign raw  = {1'b0, quo} + {{(QUO_W + 1 - OFFS_W){1'b0}}, cfg.freq_offset};
  assign push = div_vld && !qstat.full;

  always_comb begin
    item.group_path    = path;
    item.sounding_freq = freq;
    item.critical_freq = (raw[QUO_W:FREQ_W] != '0) ? '1 : raw[FREQ_W-1:0];
    item.raw           = (cfg.distance_coeff == '0) ? '0 : raw[RAW_W-1:0];
    if (path == '0) begin
      item.critical_freq = '1;
      item.status        = STAT_DIV_ZERO;
    end else if (freq == '0) begin
      item.status = STAT_DIV_ZERO;
    end else if (cfg.distance_coeff != '0 && raw[QUO_W:RAW_W] != '0) begin
      item.status = STAT_NO_PATH;
    end else begin
      item.status = STAT_OK;
    end
  end

endmodule

// ----- hdl/gdgp_back.sv -----
// ----------------------------------------------------------------------------
// gdgp_back
// Ratio test, square root and final scaling divide; holds the result register.
// ----------------------------------------------------------------------------
module gdgp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gdgp_pkg::gdgp_cfg_t   cfg,
  input  gdgp_pkg::gdgp_qstat_t qstat,
  input  gdgp_pkg::gdgp_item_t  item,
  output logic                  pop,
  gdgp_out_if.source            out_ch
);
  import gdgp_pkg::*;

  typedef struct packed {
    logic [PATH_W-1:0] group_path;
    logic [FREQ_W-1:0] sounding_freq;
    logic [FREQ_W-1:0] critical_freq;
    gdgp_status_t      status;
  } gdgp_side_t;

  localparam int unsigned SIDE_W    = $bits(gdgp_side_t);
  localparam int unsigned SQ_W      = 2 * RAW_W;
  localparam int unsigned HALF_W    = RAW_W;
  localparam int unsigned PART_W    = DCOEF_W + HALF_W;
  localparam int unsigned LHS_W     = DCOEF_W + SQ_W;
  localparam int unsigned FSQ_W     = 2 * FREQ_W;
  localparam int unsigned RHS_SH    = 16;
  localparam int unsigned RHS_W     = FSQ_W + RHS_SH;
  localparam int unsigned SQ_IN_W   = 64;
  localparam int unsigned SQ_STEPS  = SQ_IN_W / 2;
  localparam int unsigned ROOT_W    = SQ_STEPS;
  localparam int unsigned SREM_W    = ROOT_W + 2;
  localparam int unsigned X_W       = PATH_W + ROOT_W;
  localparam int unsigned DSH       = 16;
  localparam int unsigned DNUM_W    = X_W - DSH;

  logic              en;
  logic              out_vld_r;

  // stage 0: squares
  logic              vld0_r;
  logic [SQ_W-1:0]   sq0_r;
  logic [FSQ_W-1:0]  fsq0_r;
  gdgp_side_t        side0_r;
  // stage 1: coefficient partial products
  logic              vld1_r;
  logic [PART_W-1:0] lo1_r;
  logic [PART_W-1:0] hi1_r;
  logic [RHS_W-1:0]  rhs1_r;
  gdgp_side_t        side1_r;
  // stage 2: combine
  logic              vld2_r;
  logic [LHS_W-1:0]  lhs2_r;
  logic [RHS_W-1:0]  rhs2_r;
  gdgp_side_t        side2_r;
  // stage 3: ratio test
  logic [LHS_W:0]    diff3;
  logic              ge3;
  logic              vld3_r;
  logic [RHS_W-1:0]  n3_r;
  gdgp_side_t        side3_r;
  gdgp_side_t        side3_nxt;

  logic              svld_r  [SQ_STEPS];
  logic [SQ_IN_W-1:0] sv_r   [SQ_STEPS];
  logic [SREM_W-1:0] srem_r  [SQ_STEPS];
  logic [ROOT_W-1:0] sq_r    [SQ_STEPS];
  gdgp_side_t        sside_r [SQ_STEPS];

  logic              vld4_r;
  logic [X_W-1:0]    x4_r;
  gdgp_side_t        side4_r;

  logic              div_vld;
  logic [DNUM_W-1:0] quo;
  gdgp_side_t        dside;

  assign en  = !out_vld_r || out_ch.ready;
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r    <= 1'b0;
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      vld4_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld0_r    <= !qstat.empty;
      vld1_r    <= vld0_r;
      vld2_r    <= vld1_r;
      vld3_r    <= vld2_r;
      vld4_r    <= svld_r[SQ_STEPS-1];
      out_vld_r <= div_vld;
    end
  end

  assign diff3 = {{(LHS_W - RHS_W + 1){1'b0}}, rhs2_r} - {1'b0, lhs2_r};
  assign ge3   = diff3[LHS_W] || (diff3 == '0);

  always_comb begin
    side3_nxt = side2_r;
    if (side2_r.status == STAT_OK && ge3) begin
      side3_nxt.status = STAT_NO_PATH;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq0_r   <= {{RAW_W{1'b0}}, item.raw} * {{RAW_W{1'b0}}, item.raw};
      fsq0_r  <= {{FREQ_W{1'b0}}, item.sounding_freq} * {{FREQ_W{1'b0}}, item.sounding_freq};
      side0_r <= '{item.group_path, item.sounding_freq, item.critical_freq, item.status};

      lo1_r   <= {{HALF_W{1'b0}}, cfg.distance_coeff} * {{DCOEF_W{1'b0}}, sq0_r[HALF_W-1:0]};
      hi1_r   <= {{HALF_W{1'b0}}, cfg.distance_coeff} * {{DCOEF_W{1'b0}}, sq0_r[SQ_W-1:HALF_W]};
      rhs1_r  <= {fsq0_r, {RHS_SH{1'b0}}};
      side1_r <= side0_r;

      lhs2_r  <= {hi1_r, {HALF_W{1'b0}}} + {{(LHS_W - PART_W){1'b0}}, lo1_r};
      rhs2_r  <= rhs1_r;
      side2_r <= side1_r;

      n3_r    <= diff3[RHS_W-1:0];
      side3_r <= side3_nxt;

      x4_r    <= {{ROOT_W{1'b0}}, sside_r[SQ_STEPS-1].group_path} *
                 {{PATH_W{1'b0}}, sq_r[SQ_STEPS-1]};
      side4_r <= sside_r[SQ_STEPS-1];
    end
  end

  // square root, two radicand bits per stage
  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
    logic               vld_i;
    logic [SQ_IN_W-1:0] v_i;
    logic [SREM_W-1:0]  rem_i;
    logic [ROOT_W-1:0]  q_i;
    gdgp_side_t         side_i;
    logic [SREM_W+1:0]  trial;
    logic [SREM_W+1:0]  tval;
    logic [SREM_W+1:0]  sdiff;
    logic               take;

    if (s == 0) begin : g_first
      assign vld_i  = vld3_r;
      assign v_i    = {n3_r, {(SQ_IN_W - RHS_W){1'b0}}};
      assign rem_i  = '0;
      assign q_i    = '0;
      assign side_i = side3_r;
    end else begin : g_next
      assign vld_i  = svld_r[s-1];
      assign v_i    = sv_r[s-1];
      assign rem_i  = srem_r[s-1];
      assign q_i    = sq_r[s-1];
      assign side_i = sside_r[s-1];
    end

    assign trial = {rem_i, v_i[SQ_IN_W-1 -: 2]};
    assign tval  = {2'b00, q_i, 2'b01};
    assign sdiff = trial - tval;
    assign take  = trial >= tval;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        svld_r[s] <= 1'b0;
      end else if (en) begin
        svld_r[s] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[s]  <= take ? sdiff[SREM_W-1:0] : trial[SREM_W-1:0];
        sv_r[s]    <= {v_i[SQ_IN_W-3:0], 2'b00};
        sq_r[s]    <= {q_i[ROOT_W-2:0], take};
        sside_r[s] <= side_i;
      end
    end
  end

  gdgp_div #(
    .NUM_W  (DNUM_W),
    .DEN_W  (FREQ_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld4_r),
    .num       (x4_r[X_W-1:DSH]),
    .den       (side4_r.sounding_freq),
    .side_in   (side4_r),
    .out_valid (div_vld),
    .quo       (quo),
    .side_out  (dside)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.critical_freq <= dside.critical_freq;
      out_ch.status        <= dside.status;
      if (dside.status != STAT_OK) begin
        out_ch.ground_distance <= '0;
      end else if (quo[DNUM_W-1:DIST_W] != '0) begin
        out_ch.ground_distance <= '1;
      end else begin
        out_ch.ground_distance <= quo[DIST_W-1:0];
      end
    end
  end

  assign out_ch.valid = out_vld_r;

endmodule

// ----- hdl/ground_distance_from_group_path.sv -----
// ----------------------------------------------------------------------------
// ground_distance_from_group_path
// Critical frequency and ground distance of a radar echo from its group path.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per echo (group_path Q12.4 km, sounding_freq Q6.10 MHz).
//   out_ch : one beat per echo, in order (ground_distance, critical_freq,
//            status: ok, no ground path, zero path or frequency).
//   cfg_*  : write range_coeff (0), freq_offset (1), distance_coeff (2);
//            other indexes are ignored. Write only while the block is empty.
// Throughput: one echo per cycle while out_ch keeps ready high.
// Pipeline: an input beat passes the 30-stage critical frequency divider,
//   the 32-stage square root and the 32-stage distance divider, plus
//   multiply and queue stages, before its result is valid.
// Reset: clears all valid flags and the queue; config registers return to
//   their default coefficients.
// Stall: the back pipeline freezes while out_ch is held; the 4-entry queue
//   keeps the front running until it fills, then in_ch.ready drops.
// ----------------------------------------------------------------------------
`include "ground_distance_from_group_path_defines.svh"

module ground_distance_from_group_path #(
  parameter int unsigned FifoDepth = gdgp_pkg::FIFO_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gdgp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gdgp_pkg::CFG_DATA_W-1:0]   cfg_data,
  gdgp_in_if.sink                           in_ch,
  gdgp_out_if.source                        out_ch
);
  import gdgp_pkg::*;

  gdgp_cfg_t   cfg_r;
  gdgp_qstat_t qstat;
  gdgp_item_t  wr_item;
  gdgp_item_t  rd_item;
  logic        q_push;
  logic        q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_coeff    <= RCOEF_RST;
      cfg_r.freq_offset    <= OFFS_RST;
      cfg_r.distance_coeff <= DCOEF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_COEFF:    cfg_r.range_coeff    <= cfg_data[RCOEF_W-1:0];
        CFG_FREQ_OFFSET:    cfg_r.freq_offset    <= cfg_data[OFFS_W-1:0];
        CFG_DISTANCE_COEFF: cfg_r.distance_coeff <= cfg_data[DCOEF_W-1:0];
        default: ;
      endcase
    end
  end

  gdgp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg_r),
    .qstat (qstat),
    .push  (q_push),
    .item  (wr_item)
  );

  gdgp_fifo #(
    .DEPTH (FifoDepth)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (wr_item),
    .pop     (q_pop),
    .rd_item (rd_item),
    .qstat   (qstat)
  );

  gdgp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .qstat  (qstat),
    .item   (rd_item),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

  `GDGP_ASSERT_IMP(a_q_no_overflow, clk, rst_n, q_push, !qstat.full, "queue push while full")
  `GDGP_ASSERT_IMP(a_q_no_underflow, clk, rst_n, q_pop, !qstat.empty, "queue pop while empty")
  `GDGP_ASSERT_NXT(a_q_fill, clk, rst_n, q_push && !q_pop, !qstat.empty, "queue lost a beat")
  `GDGP_ASSERT_IMP(a_err_zero_dist, clk, rst_n, out_ch.valid && out_ch.status != STAT_OK,
                   out_ch.ground_distance == '0, "nonzero distance on error status")

endmodule

// ----- tb/tb_ground_distance_from_group_path.sv -----
// ----------------------------------------------------------------------------
// tb_ground_distance_from_group_path
// Drives echoes (group path, sounding frequency) through the ground distance
// block under several coefficient settings and random stalls on both
// channels. Each result beat is checked in order against a typed value or an
// in-bench fixed-point calculation of critical frequency, ratio test, distance.
// ----------------------------------------------------------------------------
module tb_ground_distance_from_group_path;
  timeunit 1ns;
  timeprecision 1ps;
  import gdgp_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] gnd;
    logic [FREQ_W-1:0] fc;
    gdgp_status_t      st;
  } echo_result_t;

  typedef struct packed {
    logic [PATH_W-1:0] path;
    logic [FREQ_W-1:0] freq;
    logic              typed;
    echo_result_t      res;
  } echo_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  gdgp_in_if  in_ch ();
  gdgp_out_if out_ch ();

  ground_distance_from_group_path DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  logic [RCOEF_W-1:0] range_coeff_q;
  logic [OFFS_W-1:0]  freq_offset_q;
  logic [DCOEF_W-1:0] dist_coeff_q;

  echo_result_t pending_results[$];
  int unsigned  errors;
  bit           quiet;
  bit           hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic echo_result_t predict_echo(input logic [15:0] p, input logic [15:0] f);
    echo_result_t res;
    logic [63:0] raw, lhs, rhs, s, d;
    res = '{gnd: '0, fc: 16'hFFFF, st: STAT_DIV_ZERO};
    if (p == 0) return res;
    raw = (64'(range_coeff_q) * f) / (64'd256 * p) + freq_offset_q;
    res.fc = (raw > 64'hFFFF) ? 16'hFFFF : raw[15:0];
    if (f == 0) return res;
    res.st = STAT_NO_PATH;
    rhs = 64'd65536 * f * f;
    if (dist_coeff_q != 0 && raw >= (64'd1 << 24)) return res;
    lhs = 64'(dist_coeff_q) * raw * raw;
    if (lhs >= rhs) return res;
    s = int_sqrt((rhs - lhs) << 16);
    d = (64'(p) * s) / (64'd65536 * f);
    res.gnd = (d > 64'hFFFF) ? 16'hFFFF : d[15:0];
    res.st = STAT_OK;
    return res;
  endfunction

  // result side: backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    echo_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat gnd=%0d fc=%0d status=%0d", $time,
                 out_ch.ground_distance, out_ch.critical_freq, out_ch.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.ground_distance !== want.gnd) begin
          $display("%0t: ground_distance expected %0d actual %0d", $time,
                   want.gnd, out_ch.ground_distance);
          errors++;
        end
        if (out_ch.critical_freq !== want.fc) begin
          $display("%0t: critical_freq expected %0d actual %0d", $time,
                   want.fc, out_ch.critical_freq);
          errors++;
        end
        if (out_ch.status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.st, out_ch.status);
          errors++;
        end
      end
    end
  end

  task automatic send_echo(input logic [15:0] p, input logic [15:0] f,
                           input bit typed, input echo_result_t typed_res);
    in_ch.valid <= 1'b1;
    in_ch.group_path <= p;
    in_ch.sounding_freq <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(typed ? typed_res : predict_echo(p, f));
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input gdgp_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RANGE_COEFF:    range_coeff_q = val[RCOEF_W-1:0];
      CFG_FREQ_OFFSET:    freq_offset_q = val[OFFS_W-1:0];
      CFG_DISTANCE_COEFF: dist_coeff_q  = val[DCOEF_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_coeffs(input logic [21:0] rc, input logic [15:0] fo,
                            input logic [15:0] dc);
    write_reg(CFG_RANGE_COEFF, rc);
    write_reg(CFG_FREQ_OFFSET, 22'(fo));
    write_reg(CFG_DISTANCE_COEFF, 22'(dc));
  endtask

  task automatic random_echoes(input int n);
    logic [15:0] p, f;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        7: begin
          p = 16'($urandom);
          f = 16'($urandom);
        end
        8: begin
          p = ($urandom_range(0, 1)) ? 16'hFFFF : 16'($urandom_range(0, 2));
          f = ($urandom_range(0, 1)) ? 16'hFFFF : 16'($urandom_range(0, 2));
        end
        9: begin
          p = 16'($urandom_range(1600, 64000));
          f = 16'($urandom);
        end
        default: begin
          p = 16'($urandom_range(1600, 64000));
          f = 16'($urandom_range(1024, 30720));
        end
      endcase
      send_echo(p, f, 1'b0, '0);
    end
  endtask

  echo_row_t directed [13];

  initial begin
    directed = '{
      '{16'd0,     16'd0,     1'b1, '{16'd0, 16'hFFFF, STAT_DIV_ZERO}},
      '{16'd0,     16'hFFFF,  1'b1, '{16'd0, 16'hFFFF, STAT_DIV_ZERO}},
      '{16'd16,    16'd0,     1'b1, '{16'd0, 16'd208,  STAT_DIV_ZERO}},
      '{16'hFFFF,  16'd0,     1'b1, '{16'd0, 16'd208,  STAT_DIV_ZERO}},
      '{16'd1,     16'hFFFF,  1'b1, '{16'd0, 16'hFFFF, STAT_NO_PATH}},
      '{16'hFFFF,  16'hFFFF,  1'b0, '0},
      '{16'hFFFF,  16'd1,     1'b0, '0},
      '{16'd1,     16'd1,     1'b0, '0},
      '{16'd4800,  16'd10240, 1'b0, '0},
      '{16'd1600,  16'd30720, 1'b0, '0},
      '{16'd64000, 16'd2048,  1'b0, '0},
      '{16'd32768, 16'd32768, 1'b0, '0},
      '{16'd16,    16'd30720, 1'b0, '0}
    };
    errors = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    range_coeff_q = RCOEF_RST;
    freq_offset_q = OFFS_RST;
    dist_coeff_q = DCOEF_RST;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.group_path = '0;
    in_ch.sounding_freq = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_echo(directed[i].path, directed[i].freq, directed[i].typed, directed[i].res);
    random_echoes(240);
    drain_results();

    set_coeffs(22'($urandom), 16'($urandom), 16'($urandom));
    random_echoes(250);
    drain_results();

    // zero coefficients: distance equals path; receiver holds off once at the start
    set_coeffs('0, '0, '0);
    hold_req = 1'b1;
    random_echoes(250);
    drain_results();

    set_coeffs(22'h3FFFFF, 16'hFFFF, 16'hFFFF);
    random_echoes(250);
    drain_results();

    set_coeffs('0, 16'hFFFF, 16'($urandom));
    random_echoes(250);
    drain_results();

    // unmapped index is ignored
    set_coeffs(RCOEF_RST, OFFS_RST, DCOEF_RST);
    cfg_we <= 1'b1;
    cfg_index <= 2'd3;
    cfg_data <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    random_echoes(250);
    drain_results();

    set_coeffs(22'($urandom), 16'($urandom_range(0, 2048)),
               16'($urandom_range(20000, 65535)));
    quiet = 1'b1;
    random_echoes(250);
    drain_results();

    repeat (150) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/gdgp_pkg.sv
hdl/gdgp_if.sv
hdl/gdgp_div.sv
hdl/gdgp_fifo.sv
hdl/gdgp_front.sv
hdl/gdgp_back.sv
hdl/ground_distance_from_group_path.sv
tb/tb_ground_distance_from_group_path.sv
